@@ hdl/iof_pkg.sv @@
// ----------------------------------------------------------------------------
// Interval overlap fraction package
// Shared types, codes and default sizes for the interval overlap block.
// ----------------------------------------------------------------------------
package iof_pkg;

  localparam int unsigned MaxIntervals = 1024;
  localparam int unsigned TimeBits     = 48;
  localparam int unsigned FractionBits = 16;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_REWIND = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_LEN = 2'd2,
    STAT_RSVD    = 2'd3
  } status_e;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] time_start;
    logic [47:0] time_stop;
  } in_word_t;

  typedef struct packed {
    logic [16:0] fraction;
    logic [10:0] cursor_position;
    logic [1:0]  status;
  } out_word_t;

endpackage

@@ hdl/iof_table.sv @@
// ----------------------------------------------------------------------------
// Interval table
// Synchronous memory holding the start and stop of each stored interval.
// ----------------------------------------------------------------------------
module iof_table
  import iof_pkg::*;
#(
  parameter int unsigned Depth = MaxIntervals,
  parameter int unsigned TW    = TimeBits,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [TW-1:0] wstart_i,
  input  logic [TW-1:0] wstop_i,
  input  logic [AW-1:0] raddr_i,
  output logic [TW-1:0] rstart_o,
  output logic [TW-1:0] rstop_o
);

  logic [2*TW-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wstop_i};
    end
    {rstart_o, rstop_o} <= mem[raddr_i];
  end

endmodule

@@ hdl/iof_divider.sv @@
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider for floor(num*2^FB/den), 2^FB if num >= den; one quotient bit a cycle.
// ----------------------------------------------------------------------------
module iof_divider
  import iof_pkg::*;
#(
  parameter int unsigned TW = TimeBits,
  parameter int unsigned FB = FractionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [TW-1:0] num_i,
  input  logic [TW-1:0] den_i,
  output logic        done_o,
  output logic [FB:0] quot_o
);

  localparam int unsigned CW = $clog2(FB + 1);

  logic [TW:0]   rem_q, rem_d;
  logic [TW-1:0] den_q;
  logic [FB:0]   quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [TW:0]   shifted;

  // One shift and conditional subtract per cycle.
  always_comb begin
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[TW-1:0], 1'b0};
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      if (num_i >= den_i) begin
        quot_d = {1'b1, {FB{1'b0}}};
        done_d = 1'b1;
      end else begin
        quot_d = '0;
        cnt_d  = CW'(FB);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = shifted - {1'b0, den_q};
        quot_d = {quot_q[FB-1:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[FB-1:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hdl/interval_overlap_fraction.sv @@
// ----------------------------------------------------------------------------
// Interval overlap fraction
// Table of good-time intervals with a cursor; answers covered bin fractions.
// ----------------------------------------------------------------------------
// Clear, append and rewind go from ST_IDLE to ST_DONE, which registers the strobe.
// A query passes ST_READ and ST_EVAL for each interval examined, ST_READ alone
// when the walk runs off the table end, ST_DIV for each partial overlap divided in
// the serial divider, then ST_DONE. A new word is taken the cycle after the strobe.
// busy stays high through the result strobe; the receiver cannot stall.
// Reset clears the interval count and cursor; the table needs no clearing.
module interval_overlap_fraction
  import iof_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervals
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word_i,
  output logic      done_o,
  output out_word_t out_word_o
);

  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned TW = TimeBits;
  localparam int unsigned FB = FractionBits;
  localparam logic [FB:0] One = {1'b1, {FB{1'b0}}};

  state_e          state_q, state_d;
  logic [1:0]      mode_q;
  logic [TW-1:0]   t0_q, t1_q;
  logic [CW-1:0]   count_q, count_d, cursor_q, cursor_d;
  logic [FB+1:0]   sum_q, sum_d;
  logic            bad_q, bad_d;
  logic [FB:0]     frac_q, frac_d;
  logic [1:0]      stat_q, stat_d;
  logic            done_q;

  logic [TW-1:0]   s_rd, e_rd;
  logic            we;
  logic            div_start, div_done;
  logic [FB:0]     div_q;
  logic [TW-1:0]   lo, hi;
  logic            accept;

  assign accept = start && !busy;
  assign we     = accept && (in_word_i.mode == MODE_APPEND) && (count_q < CW'(MAX_INTERVALS));

  iof_table #(.Depth(MAX_INTERVALS), .TW(TW)) u_table (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (count_q[AW-1:0]),
    .wstart_i (in_word_i.time_start),
    .wstop_i  (in_word_i.time_stop),
    .raddr_i  (cursor_q[AW-1:0]),
    .rstart_o (s_rd),
    .rstop_o  (e_rd)
  );

  assign lo = (t0_q > s_rd) ? t0_q : s_rd;
  assign hi = (t1_q < e_rd) ? t1_q : e_rd;

  iof_divider #(.TW(TW), .FB(FB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (hi - lo),
    .den_i   (t1_q - t0_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Next-state and datapath update.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    sum_d     = sum_q;
    bad_d     = bad_q;
    frac_d    = frac_q;
    stat_d    = stat_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          frac_d = '0;
          stat_d = STAT_OK;
          sum_d  = '0;
          bad_d  = 1'b0;
          unique case (mode_e'(in_word_i.mode))
            MODE_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
              state_d  = ST_DONE;
            end
            MODE_APPEND: begin
              if (count_q < CW'(MAX_INTERVALS)) count_d = count_q + 1'b1;
              else stat_d = STAT_FULL;
              state_d = ST_DONE;
            end
            MODE_REWIND: begin
              cursor_d = '0;
              state_d  = ST_DONE;
            end
            MODE_QUERY: state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        // Table read is issued at the cursor; data arrives next cycle.
        if (cursor_q < count_q) state_d = ST_EVAL;
        else state_d = ST_DONE;
      end
      ST_EVAL: begin
        if (t1_q <= s_rd) begin
          state_d = ST_DONE;
        end else if (t0_q >= s_rd && t1_q <= e_rd) begin
          if (t1_q == e_rd) cursor_d = cursor_q + 1'b1;
          frac_d  = One;
          stat_d  = STAT_OK;
          bad_d   = 1'b0;
          sum_d   = {1'b0, One};
          state_d = ST_DONE;
        end else begin
          if (t0_q < e_rd && t1_q <= t0_q) bad_d = 1'b1;
          if (t0_q < e_rd && t1_q > t0_q && hi > lo) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else if (t1_q < e_rd) begin
            state_d = ST_DONE;
          end else begin
            cursor_d = cursor_q + 1'b1;
            state_d  = ST_READ;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sum_d = sum_q + {1'b0, div_q};
          if (sum_d > {1'b0, One}) sum_d = {1'b0, One};
          if (t1_q < e_rd) begin
            state_d = ST_DONE;
          end else begin
            cursor_d = cursor_q + 1'b1;
            state_d  = ST_READ;
          end
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    // Finish a query: pick the fraction and status.
    if (state_q != ST_IDLE && state_d == ST_DONE && mode_q == MODE_QUERY
        && frac_d != One) begin
      if (bad_d) begin
        frac_d = '0;
        stat_d = STAT_BAD_LEN;
      end else begin
        frac_d = sum_d[FB:0];
      end
    end
  end

  // Capture the item and register the datapath results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_word_i.mode;
      t0_q   <= in_word_i.time_start;
      t1_q   <= in_word_i.time_stop;
    end
    sum_q  <= sum_d;
    bad_q  <= bad_d;
    frac_q <= frac_d;
    stat_q <= stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      done_q   <= (state_q == ST_DONE);
    end
  end

  // Result word is held in registers; done_o marks it for one cycle.
  always_comb begin
    busy                       = (state_q != ST_IDLE) || done_q;
    done_o                     = done_q;
    out_word_o.fraction        = frac_q;
    out_word_o.cursor_position = 11'(cursor_q);
    out_word_o.status          = stat_q;
  end

endmodule
